// ===== rtl/tspcm_pkg.sv =====
package tspcm_pkg;

	localparam int PACKET_BYTES = 188;
	localparam int PID_IDX_W    = 13;
	localparam int PID_COUNT    = 1 << PID_IDX_W;

	localparam int POS_W = 48;
	localparam int CNT_W = 32;

	localparam logic [7:0]       SYNC_MARK = 8'h47;
	localparam logic [12:0]      NULL_PID  = 13'h1fff;
	localparam logic [1:0]       AFC_LIMIT = 2'h2;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// Queue between the classifier and the checker.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// Result queue at the output.
	localparam int R_DEPTH = 2;
	localparam int R_PTR_W = $clog2(R_DEPTH);
	localparam int R_CNT_W = R_PTR_W + 1;

	typedef enum logic [1:0] {
		KIND_LOST_SYNC,
		KIND_ERROR_BIT,
		KIND_GOOD
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic                 check_cc;
		logic [PID_IDX_W-1:0] idx;
		logic [3:0]           cc;
		logic [POS_W-1:0]     pos;
	} q_item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic             accepted;
		logic             error_bit_seen;
		logic             spacing_error;
		logic             continuity_error;
		logic [CNT_W-1:0] error_bit_total;
		logic [CNT_W-1:0] spacing_error_total;
		logic [CNT_W-1:0] continuity_error_total;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/tspcm_front.sv =====
module tspcm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           sync_value,
	input  logic                 error_indicator,
	input  logic [12:0]          pid,
	input  logic [3:0]           counter_value,
	input  logic [1:0]           adaptation_control,
	input  logic [47:0]          byte_position,
	input  tspcm_pkg::back_stat_t bstat,
	output tspcm_pkg::q_item_t   head,
	output logic                 head_valid
);
	import tspcm_pkg::*;

	q_item_t             q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	q_item_t             item_d;
	logic                do_push;

	// Classify the header on the way in so the checker only sees a kind.
	always_comb begin
		if (sync_value != SYNC_MARK) begin
			item_d.kind = KIND_LOST_SYNC;
		end else if (error_indicator) begin
			item_d.kind = KIND_ERROR_BIT;
		end else begin
			item_d.kind = KIND_GOOD;
		end
		item_d.check_cc = (pid != NULL_PID) && (adaptation_control < AFC_LIMIT);
		item_d.idx      = pid[PID_IDX_W-1:0];
		item_d.cc       = counter_value;
		item_d.pos      = byte_position;
	end

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH)) || bstat.clearing;
	assign do_push    = push && !full;
	assign head       = q_mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (bstat.pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, bstat.pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/tspcm_back.sv =====
module tspcm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tspcm_pkg::q_item_t    head,
	input  logic                  head_valid,
	output tspcm_pkg::back_stat_t bstat,
	input  logic                  res_pop,
	output tspcm_pkg::result_t    res,
	output logic                  res_empty
);
	import tspcm_pkg::*;

	logic [4:0]           cc_mem_q [PID_COUNT];
	logic                 clearing_q;
	logic [PID_IDX_W-1:0] clr_idx_q;

	logic                 valid_s1;
	q_item_t              item_s1;
	logic [4:0]           rd_s1;

	logic [POS_W:0]       next_exp_q;
	logic [CNT_W-1:0]     err_cnt_q;
	logic [CNT_W-1:0]     spc_cnt_q;
	logic [CNT_W-1:0]     cont_cnt_q;

	result_t              r_mem_q [R_DEPTH];
	logic [R_PTR_W-1:0]   r_wr_ptr_q;
	logic [R_PTR_W-1:0]   r_rd_ptr_q;
	logic [R_CNT_W-1:0]   r_cnt_q;

	logic                 r_full;
	logic                 adv;
	logic                 pop_head;
	logic                 good;
	logic                 errb;
	logic                 spacing;
	logic                 cont;
	logic                 wr_en;
	logic                 fwd;
	logic [3:0]           cc_next;
	result_t              res_d;

	assign r_full   = (r_cnt_q == R_CNT_W'(R_DEPTH));
	assign adv      = valid_s1 && !r_full;
	assign pop_head = head_valid && !clearing_q && (!valid_s1 || adv);

	assign bstat.pop      = pop_head;
	assign bstat.clearing = clearing_q;

	assign good    = (item_s1.kind == KIND_GOOD);
	assign errb    = (item_s1.kind == KIND_ERROR_BIT);
	assign cc_next = rd_s1[3:0] + 4'd1;
	assign spacing = good && (item_s1.pos != '0) && ({1'b0, item_s1.pos} != next_exp_q);
	assign cont    = good && item_s1.check_cc && rd_s1[4] && (cc_next != item_s1.cc);
	assign wr_en   = adv && good;
	// The entry written this cycle is not yet visible to a read of the same PID.
	assign fwd     = wr_en && (item_s1.idx == head.idx);

	always_comb begin
		res_d.accepted               = good;
		res_d.error_bit_seen         = errb;
		res_d.spacing_error          = spacing;
		res_d.continuity_error       = cont;
		res_d.error_bit_total        = errb ? sat_inc(err_cnt_q) : err_cnt_q;
		res_d.spacing_error_total    = spacing ? sat_inc(spc_cnt_q) : spc_cnt_q;
		res_d.continuity_error_total = cont ? sat_inc(cont_cnt_q) : cont_cnt_q;
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			cc_mem_q[clr_idx_q] <= '0;
		end else if (wr_en) begin
			cc_mem_q[item_s1.idx] <= {1'b1, item_s1.cc};
		end
		if (pop_head) begin
			item_s1 <= head;
			rd_s1   <= fwd ? {1'b1, item_s1.cc} : cc_mem_q[head.idx];
		end
		if (adv) begin
			r_mem_q[r_wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			valid_s1   <= 1'b0;
			next_exp_q <= (POS_W+1)'(PACKET_BYTES);
			err_cnt_q  <= '0;
			spc_cnt_q  <= '0;
			cont_cnt_q <= '0;
			r_wr_ptr_q <= '0;
			r_rd_ptr_q <= '0;
			r_cnt_q    <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + PID_IDX_W'(1);
				if (clr_idx_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop_head) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				err_cnt_q  <= res_d.error_bit_total;
				spc_cnt_q  <= res_d.spacing_error_total;
				cont_cnt_q <= res_d.continuity_error_total;
				r_wr_ptr_q <= r_wr_ptr_q + R_PTR_W'(1);
			end
			if (wr_en) begin
				next_exp_q <= {1'b0, item_s1.pos} + (POS_W+1)'(PACKET_BYTES);
			end
			if (res_pop && !res_empty) begin
				r_rd_ptr_q <= r_rd_ptr_q + R_PTR_W'(1);
			end
			case ({adv, res_pop && !res_empty})
				2'b10:   r_cnt_q <= r_cnt_q + R_CNT_W'(1);
				2'b01:   r_cnt_q <= r_cnt_q - R_CNT_W'(1);
				default: r_cnt_q <= r_cnt_q;
			endcase
		end
	end

	assign res       = r_mem_q[r_rd_ptr_q];
	assign res_empty = (r_cnt_q == '0);

endmodule

// ===== rtl/ts_packet_continuity_monitor.sv =====
// An item passes the input queue and check stage, then shows as a result (empty low).
// Throughput: one item per cycle while the result queue has room, set by the per-PID table
// read-modify-write of counters, with the entry just written forwarded to a same-PID read.
// Reset: arst_n clears all control state at once; the table of 8192 entries is then cleared
// one entry per cycle, and full stays high until the whole table is cleared.
module ts_packet_continuity_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  sync_value,
	input  logic        error_indicator,
	input  logic [12:0] pid,
	input  logic [3:0]  counter_value,
	input  logic [1:0]  adaptation_control,
	input  logic [47:0] byte_position,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic        error_bit_seen,
	output logic        spacing_error,
	output logic        continuity_error,
	output logic [31:0] error_bit_total,
	output logic [31:0] spacing_error_total,
	output logic [31:0] continuity_error_total
);
	import tspcm_pkg::*;

	// The front end classifies each header (lost sync, error bit or good packet) and
	// parks it in a four-entry queue. The back end pulls items from that queue, reads
	// the last counter for the PID, checks spacing and continuity, updates the
	// saturating totals and writes one result item into a two-entry output queue, so
	// one waiting result does not stop the next header from being checked.
	q_item_t    head;
	logic       head_valid;
	back_stat_t bstat;
	result_t    res;

	tspcm_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.sync_value         (sync_value),
		.error_indicator    (error_indicator),
		.pid                (pid),
		.counter_value      (counter_value),
		.adaptation_control (adaptation_control),
		.byte_position      (byte_position),
		.bstat              (bstat),
		.head               (head),
		.head_valid         (head_valid)
	);

	// The back end also owns the counter table and runs the clearing sweep after reset.
	tspcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.bstat      (bstat),
		.res_pop    (pop),
		.res        (res),
		.res_empty  (empty)
	);

	// Every result item carries the totals as they stand after that item.
	assign accepted               = res.accepted;
	assign error_bit_seen         = res.error_bit_seen;
	assign spacing_error          = res.spacing_error;
	assign continuity_error       = res.continuity_error;
	assign error_bit_total        = res.error_bit_total;
	assign spacing_error_total    = res.spacing_error_total;
	assign continuity_error_total = res.continuity_error_total;

endmodule

// ===== rtl/tspcm_checker.sv =====
module tspcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        accepted,
	input logic        error_bit_seen,
	input logic        spacing_error,
	input logic        continuity_error,
	input logic [31:0] error_bit_total,
	input logic [31:0] spacing_error_total,
	input logic [31:0] continuity_error_total
);

	// The table sweep must hold off input right after reset.
	a_full_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> full)
		else $error("full low right after reset");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> empty)
		else $error("result shown right after reset");

	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(accepted && error_bit_seen) &&
			(!(spacing_error || continuity_error) || accepted))
		else $error("result flags contradict each other");

	a_totals_follow_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!error_bit_seen || error_bit_total != 32'd0) &&
			(!spacing_error || spacing_error_total != 32'd0) &&
			(!continuity_error || continuity_error_total != 32'd0))
		else $error("error flag set with a zero total");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result withdrawn");

endmodule

bind ts_packet_continuity_monitor tspcm_checker u_tspcm_checker (.*);
